### hdl/tac_pkg.sv
// Shared types and constants for the two's complement arithmetic unit.
// No dependencies; imported by tac_ctrl, tac_dp and twos_complement_alu.
package tac_pkg;

    // Internal arithmetic width; item fields stay 8 bits wide.
    localparam int WIDTH    = 8;
    localparam int BIT_W    = $clog2(WIDTH);
    localparam int OP_W     = 3;
    localparam int FIELD_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_FACT = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FACT_NEG = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [FIELD_W-1:0] operand_a;
        logic signed [FIELD_W-1:0] operand_b;
    } req_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] result_value;
        logic signed [FIELD_W-1:0] remainder_value;
        logic                      overflow_flag;
        logic [STATUS_W-1:0]       status;
    } rsp_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic fact_step;
        logic out_write;
    } tac_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic run_div;
        logic run_fact;
        logic div_last;
        logic fact_done;
    } tac_sts_t;

endpackage

### hdl/tac_ctrl.sv
// Sequencer for the arithmetic unit: handshakes and iteration control.
// Depends on tac_pkg (command and status structs).
module tac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tac_pkg::tac_cmd_t cmd,
    input  tac_pkg::tac_sts_t sts
);
    import tac_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_DIV      = 3'd2;
    localparam logic [2:0] S_FACT     = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = valid_reg;
    assign out_free  = !valid_reg || rsp_ready;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg && !rsp_ready;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.run_div)
                    state_next = S_DIV;
                else if (sts.run_fact)
                    state_next = S_FACT;
                else
                    state_next = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_DONE;
            end
            S_FACT:
            begin
                if (sts.fact_done)
                    state_next = S_DONE;
                else
                    cmd.fact_step = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_write = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### hdl/tac_dp.sv
// Datapath: operand registers, divide and factorial iteration registers, result register.
// Depends on tac_pkg (item types, opcodes, command and status structs).
module tac_dp (
    input  logic               clk,
    input  tac_pkg::req_item_t req,
    output tac_pkg::rsp_item_t rsp,
    input  tac_pkg::tac_cmd_t  cmd,
    output tac_pkg::tac_sts_t  sts
);
    import tac_pkg::*;

    logic [OP_W-1:0]  op_reg;
    logic [WIDTH-1:0] a_reg, b_reg;
    logic [WIDTH-1:0] acc_reg;      // factorial product
    logic [WIDTH-1:0] iter_reg;     // factorial multiplier
    logic [WIDTH-1:0] dvd_reg;      // dividend magnitude in, quotient out
    logic [WIDTH-1:0] rem_reg;      // partial remainder
    logic [BIT_W-1:0] bit_reg;
    rsp_item_t        rsp_reg, rsp_next;

    logic [WIDTH-1:0] a_in, b_in, a_mag, b_mag;
    logic [WIDTH-1:0] r_shift, r_sub;
    logic             r_ge;
    logic [WIDTH-1:0] fact_prod, mul_prod;
    logic [WIDTH-1:0] sum, diff, res, rem;
    logic             ovf;
    logic [STATUS_W-1:0] st;

    // Sign-extend the 8-bit fields into the working width
    assign a_in  = WIDTH'(req.operand_a);
    assign b_in  = WIDTH'(req.operand_b);
    assign a_mag = a_in[WIDTH-1] ? (WIDTH'(0) - a_in) : a_in;
    assign b_mag = b_reg[WIDTH-1] ? (WIDTH'(0) - b_reg) : b_reg;

    // Restoring division step
    assign r_shift = {rem_reg[WIDTH-2:0], dvd_reg[WIDTH-1]};
    assign r_ge    = (r_shift >= b_mag);
    assign r_sub   = r_shift - b_mag;

    assign fact_prod = WIDTH'(acc_reg * iter_reg);
    assign mul_prod  = WIDTH'(a_reg * b_reg);
    assign sum       = a_reg + b_reg;
    assign diff      = a_reg - b_reg;

    assign sts.run_div   = (op_reg == OP_DIV) && (b_reg != '0);
    assign sts.run_fact  = (op_reg == OP_FACT) && !a_reg[WIDTH-1];
    assign sts.div_last  = (bit_reg == '0);
    assign sts.fact_done = (iter_reg > a_reg) || (acc_reg == '0);

    always_comb
    begin
        res = '0;
        rem = '0;
        ovf = 1'b0;
        st  = ST_OK;
        unique case (op_reg)
            OP_ADD:
            begin
                res = sum;
                ovf = !(a_reg[WIDTH-1] ^ b_reg[WIDTH-1]) && (a_reg[WIDTH-1] ^ sum[WIDTH-1]);
            end
            OP_SUB:
            begin
                res = diff;
                ovf = (a_reg[WIDTH-1] ^ b_reg[WIDTH-1]) && (a_reg[WIDTH-1] ^ diff[WIDTH-1]);
            end
            OP_MUL:
                res = mul_prod;
            OP_FACT:
            begin
                if (a_reg[WIDTH-1])
                    st = ST_FACT_NEG;
                else
                    res = acc_reg;
            end
            OP_DIV:
            begin
                if (b_reg == '0)
                    st = ST_DIV_ZERO;
                else
                begin
                    res = (a_reg[WIDTH-1] ^ b_reg[WIDTH-1]) ? (WIDTH'(0) - dvd_reg) : dvd_reg;
                    rem = a_reg[WIDTH-1] ? (WIDTH'(0) - rem_reg) : rem_reg;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        rsp_next.result_value    = FIELD_W'(res);
        rsp_next.remainder_value = FIELD_W'(rem);
        rsp_next.overflow_flag   = ovf;
        rsp_next.status          = st;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.operation;
            a_reg    <= a_in;
            b_reg    <= b_in;
            dvd_reg  <= a_mag;
            rem_reg  <= '0;
            bit_reg  <= BIT_W'(WIDTH - 1);
            acc_reg  <= WIDTH'(1);
            iter_reg <= WIDTH'(2);
        end
        if (cmd.div_step)
        begin
            rem_reg <= r_ge ? r_sub : r_shift;
            dvd_reg <= {dvd_reg[WIDTH-2:0], r_ge};
            bit_reg <= bit_reg - BIT_W'(1);
        end
        if (cmd.fact_step)
        begin
            acc_reg  <= fact_prod;
            iter_reg <= iter_reg + WIDTH'(1);
        end
        if (cmd.out_write)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

### hdl/twos_complement_alu.sv
// Top level of the two's complement arithmetic unit.
// Depends on tac_pkg, tac_ctrl and tac_dp.
//
// Takes one request item (operation, operand_a, operand_b) at a time and
// returns one response item per request, in order. Add, subtract, multiply
// and unused opcodes go from acceptance to the result register through
// load, dispatch and write. Divide runs restoring division one quotient bit
// per cycle on a single shared subtract/compare unit. Factorial runs one
// multiply per cycle through a single WIDTH x WIDTH multiplier until the
// multiplier passes operand_a or the product wraps to zero, and the
// sequencer checks for that end before each multiply; at WIDTH = 8 the run
// is longest once operand_a is 10 or more. Division by zero and negative
// factorial operands skip the iteration and return a zero result with an
// error status. A finished response sits in an output register, so a new
// request is taken as soon as the sequencer is back in idle, even while the
// previous response waits for rsp_ready; a response that cannot be written
// because the register is still full holds the sequencer until it drains.
module twos_complement_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tac_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tac_pkg::rsp_item_t rsp
);
    import tac_pkg::*;

    tac_cmd_t cmd;
    tac_sts_t sts;

    // Sequencer: owns the handshakes and sequences the divide/factorial iterations
    tac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: operand capture, iteration registers, response register
    tac_dp u_dp (
        .clk (clk),
        .req (req),
        .rsp (rsp),
        .cmd (cmd),
        .sts (sts)
    );

endmodule
